// File: rtl/core/hcd_pkg.sv
`timescale 1ns / 1ps

package hcd_pkg;

  // default width of the chunk length accumulator
  localparam int unsigned LengthBitsDefault = 32;

  localparam logic [7:0] ChrCr   = 8'h0d;
  localparam logic [7:0] ChrLf   = 8'h0a;
  localparam logic [7:0] ChrSemi = 8'h3b;
  localparam logic [7:0] CtrlMax = 8'h1f;
  localparam logic [7:0] ChrDel  = 8'h7f;
  localparam logic [7:0] HighMin = 8'h80;

  typedef enum logic [3:0] {
    PH_HEX_FIRST = 4'd0,
    PH_HEX_MORE  = 4'd1,
    PH_EXT       = 4'd2,
    PH_LEN_LF    = 4'd3,
    PH_PAYLOAD   = 4'd4,
    PH_DATA_CR   = 4'd5,
    PH_DATA_LF   = 4'd6,
    PH_LAST_CR   = 4'd10,
    PH_LAST_LF   = 4'd11
  } phase_e;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  // one input byte together with its decoded classes
  typedef struct packed {
    logic [7:0] data;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
    logic       is_semi;
    logic       bad_ext;
  } byte_class_t;

  typedef struct packed {
    status_e    status;
    logic       payload_valid;
    logic [7:0] payload_byte;
  } result_t;

endpackage

// File: rtl/core/hcd_if.sv
`timescale 1ns / 1ps

interface hcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface hcd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       payload_valid;
  logic [7:0] payload_byte;

  modport source (output valid, output status, output payload_valid, output payload_byte,
                  input ready);
  modport sink (input valid, input status, input payload_valid, input payload_byte,
                output ready);
endinterface

// File: rtl/core/hcd_byte_class.sv
`timescale 1ns / 1ps

module hcd_byte_class (
  input  logic [7:0]          data_i,
  output hcd_pkg::byte_class_t class_o
);
  import hcd_pkg::*;

  logic is_digit;
  logic is_alpha;
  logic is_tspecial;

  always_comb begin
    is_digit = data_i inside {[8'h30 : 8'h39]};
    is_alpha = data_i inside {[8'h41 : 8'h46], [8'h61 : 8'h66]};
    // ( ) < > @ , ; : \ " / [ ] ? = { } and space
    is_tspecial = data_i inside {8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a,
                                 8'h5c, 8'h22, 8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b,
                                 8'h7d, 8'h20};

    class_o.data    = data_i;
    class_o.is_hex  = is_digit | is_alpha;
    // letters a-f / A-F: low nibble 1..6 maps to 10..15
    class_o.hex_val = is_alpha ? (data_i[3:0] + 4'd9) : data_i[3:0];
    class_o.is_cr   = (data_i == ChrCr);
    class_o.is_lf   = (data_i == ChrLf);
    class_o.is_semi = (data_i == ChrSemi);
    class_o.bad_ext = is_tspecial || (data_i <= CtrlMax) || (data_i == ChrDel) ||
                      (data_i >= HighMin);
  end

endmodule

// File: rtl/core/hcd_parser.sv
`timescale 1ns / 1ps

module hcd_parser #(
  parameter int unsigned LengthBits = hcd_pkg::LengthBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 collect_i,
  input  logic                 item_valid_i,
  input  hcd_pkg::byte_class_t item_i,
  output logic                 advance_o,
  hcd_out_if.source            out_o
);
  import hcd_pkg::*;

  phase_e                phase_q, phase_d;
  logic [LengthBits-1:0] len_q, len_d;
  logic [LengthBits-1:0] len_dec;
  logic                  ovf_q, ovf_d;
  status_e               final_q, final_d;
  logic                  res_valid_q, res_valid_d;
  result_t               res_q, res_d;
  logic                  consume;

  // result register frees up when empty or being taken
  assign advance_o = !res_valid_q || out_o.ready;
  assign consume   = item_valid_i && advance_o;
  assign len_dec   = len_q - {{(LengthBits-1){1'b0}}, 1'b1};

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    ovf_d   = ovf_q;
    final_d = final_q;
    res_d.payload_valid = 1'b0;
    res_d.payload_byte  = '0;

    if (final_q == ST_BUSY) begin
      case (phase_q)
        PH_HEX_FIRST: begin
          if (item_i.is_hex) begin
            len_d   = {{(LengthBits-4){1'b0}}, item_i.hex_val};
            ovf_d   = 1'b0;
            phase_d = PH_HEX_MORE;
          end else begin
            final_d = ST_ERROR;
          end
        end
        PH_HEX_MORE: begin
          if (item_i.is_hex) begin
            if (len_q[LengthBits-1 -: 4] != 4'd0) begin
              ovf_d = 1'b1;
            end
            len_d = {len_q[LengthBits-5:0], item_i.hex_val};
          end else if (item_i.is_semi) begin
            phase_d = PH_EXT;
          end else if (item_i.is_cr) begin
            phase_d = PH_LEN_LF;
          end else begin
            final_d = ST_ERROR;
          end
        end
        PH_EXT: begin
          if (item_i.is_cr) begin
            phase_d = PH_LEN_LF;
          end else if (item_i.bad_ext) begin
            final_d = ST_ERROR;
          end
        end
        PH_LEN_LF: begin
          if (!item_i.is_lf || ovf_q) begin
            final_d = ST_ERROR;
          end else if (len_q != '0) begin
            phase_d = PH_PAYLOAD;
          end else begin
            phase_d = PH_LAST_CR;
          end
        end
        PH_PAYLOAD: begin
          if (collect_i) begin
            res_d.payload_valid = 1'b1;
            res_d.payload_byte  = item_i.data;
          end
          len_d = len_dec;
          if (len_dec == '0) begin
            phase_d = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (item_i.is_cr) phase_d = PH_DATA_LF;
          else final_d = ST_ERROR;
        end
        PH_DATA_LF: begin
          if (item_i.is_lf) phase_d = PH_HEX_FIRST;
          else final_d = ST_ERROR;
        end
        PH_LAST_CR: begin
          if (item_i.is_cr) phase_d = PH_LAST_LF;
          else final_d = ST_ERROR;
        end
        PH_LAST_LF: begin
          final_d = item_i.is_lf ? ST_DONE : ST_ERROR;
        end
        default: begin
          final_d = ST_ERROR;
        end
      endcase
    end

    res_d.status = final_d;
    res_valid_d  = consume ? 1'b1 : (res_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEX_FIRST;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      final_q     <= ST_BUSY;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (consume) begin
        phase_q <= phase_d;
        len_q   <= len_d;
        ovf_q   <= ovf_d;
        final_q <= final_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = res_valid_q;
  assign out_o.status        = res_q.status;
  assign out_o.payload_valid = res_q.payload_valid;
  assign out_o.payload_byte  = res_q.payload_byte;

  // payload only flows while the body is still being parsed
  a_payload_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.payload_valid |-> res_q.status == ST_BUSY)
    else $error("payload result with terminal status");

  // done and error are sticky
  a_final_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_q != ST_BUSY |=> final_q == $past(final_q))
    else $error("terminal status changed");

  // payload phase never sits on an exhausted count
  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> len_q != '0)
    else $error("payload phase with zero remaining length");

endmodule

// File: rtl/core/http_chunked_decoder.sv
`timescale 1ns / 1ps

// http chunked body decoder
// in_i  : one body byte per request (data_byte), valid/ready handshake
// out_o : one result per input byte: status (0 busy, 1 done, 2 error),
//         payload_valid and payload_byte (zero when not a payload byte)
// cfg   : cfg_we_i writes cfg_wdata_i into collect_payload (reset 1);
//         write only while no request is in flight
// path: a byte accepted from in_i passes the input register, then the
//   parse logic into the result register
// throughput: one byte per cycle while out_o.ready stays high, set by the
//   phase/length update in the parser
// reset: parser waits for the first hex digit, status busy, both
//   pipeline stages empty
// receiver stall: the result register holds; the input register keeps
//   accepting until it is full, then in_i.ready drops in the same cycle
// done and error are sticky until reset; later bytes are taken and
//   answered with the same status
module http_chunked_decoder #(
  parameter int unsigned LengthBits = hcd_pkg::LengthBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  hcd_in_if.sink     in_i,
  hcd_out_if.source  out_o
);
  import hcd_pkg::*;

  logic        collect_q;
  logic        s1_valid_q;
  byte_class_t s1_q;
  byte_class_t in_class;
  logic        advance;

  // classify the byte before the input register so the parse stage stays short
  hcd_byte_class u_class (
    .data_i  (in_i.data_byte),
    .class_o (in_class)
  );

  // input stage frees up when empty or when its byte moves on
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collect_q  <= 1'b1;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) collect_q <= cfg_wdata_i;
      if (in_i.ready) s1_valid_q <= in_i.valid;
    end
  end

  // byte register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q <= in_class;
    end
  end

  // phase machine, length counter and result register
  hcd_parser #(
    .LengthBits (LengthBits)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .collect_i    (collect_q),
    .item_valid_i (s1_valid_q),
    .item_i       (s1_q),
    .advance_o    (advance),
    .out_o        (out_o)
  );

endmodule
